/* design/reciprocal_frequency_counter_unit_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the reciprocal frequency counter
// Shared forms for same-cycle and next-cycle implication checks.
// ---------------------------------------------------------------------------
`ifndef RECIPROCAL_FREQUENCY_COUNTER_UNIT_ASSERT_SVH
`define RECIPROCAL_FREQUENCY_COUNTER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define RFC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

/* design/rfc_pkg.sv */
// ---------------------------------------------------------------------------
// rfc_pkg
// Field widths, register indexes and controller/datapath signal groups.
// ---------------------------------------------------------------------------
package rfc_pkg;

  // Widths of configuration registers and result fields.
  localparam int MIN_WIN_W = 32;
  localparam int CLK_HZ_W  = 28;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W = 1;
  localparam int FREQ_W    = 40;
  localparam int OUT_EDGE_W = 32;
  localparam int OUT_TICK_W = 48;
  localparam int FRAC_BITS = 16;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MIN_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HZ   = 1'b1;

  // Register reset values.
  localparam logic [MIN_WIN_W-1:0] MIN_WIN_RESET = 32'd500000;
  localparam logic [CLK_HZ_W-1:0]  CLK_HZ_RESET  = 28'd20000000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic mul_step;
    logic div_step;
    logic out_load;
  } rfc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic close;
    logic out_free;
  } rfc_status_t;

endpackage

/* design/rfc_if.sv */
// ---------------------------------------------------------------------------
// rfc_if
// Valid/ready channels for input samples and measurement results.
// ---------------------------------------------------------------------------

// Input channel: one sampled level per transfer.
interface rfc_in_if;
  logic valid;
  logic ready;
  logic signal_level;

  modport source(output valid, output signal_level, input ready);
  modport sink(input valid, input signal_level, output ready);
endinterface

// Result channel: one closed measurement window per transfer.
interface rfc_out_if import rfc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0]     frequency_q16;
  logic [OUT_EDGE_W-1:0] edges_in_window;
  logic [OUT_TICK_W-1:0] window_ticks;

  modport source(output valid, output frequency_q16, output edges_in_window,
                 output window_ticks, input ready);
  modport sink(input valid, input frequency_q16, input edges_in_window,
               input window_ticks, output ready);
endinterface

/* design/rfc_ctrl.sv */
// ---------------------------------------------------------------------------
// rfc_ctrl
// Sequencer: accepts samples, then steps the serial multiplier and the
// serial divider when a window closes, and hands the result to the output.
// ---------------------------------------------------------------------------
`include "reciprocal_frequency_counter_unit_assert.svh"

module rfc_ctrl import rfc_pkg::*; #(
  parameter int EDGE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  rfc_status_t status,
  output rfc_cmd_t    cmd
);

  localparam int NUM_W = EDGE_BITS + CLK_HZ_W + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic              last;

  assign last = (count == '0);

  // Commands decoded from the current state.
  always_comb begin
    in_ready     = (state == S_IDLE);
    cmd.accept   = in_valid && in_ready;
    cmd.mul_step = (state == S_MUL);
    cmd.div_step = (state == S_DIV);
    cmd.out_load = (state == S_DONE) && status.out_free;
  end

  // State and step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.accept && status.close) begin
            state <= S_MUL;
            count <= CNT_W'(EDGE_BITS - 1);
          end
        end
        S_MUL: begin
          if (last) begin
            state <= S_DIV;
            count <= CNT_W'(NUM_W - 1);
          end else begin
            count <= count - 1'b1;
          end
        end
        S_DIV: begin
          if (last) begin
            state <= S_DONE;
          end else begin
            count <= count - 1'b1;
          end
        end
        S_DONE: begin
          if (status.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A closing sample starts the multiply.
  `RFC_ASSERT_NXT(a_close_starts_mul, clk, rst, cmd.accept && status.close, state == S_MUL)
  // The last divide step leads to the hand-off state.
  `RFC_ASSERT_NXT(a_div_ends, clk, rst, cmd.div_step && last, state == S_DONE)
  // A loaded result returns the sequencer to accepting samples.
  `RFC_ASSERT_NXT(a_load_returns, clk, rst, cmd.out_load, in_ready)

endmodule

/* design/rfc_datapath.sv */
// ---------------------------------------------------------------------------
// rfc_datapath
// Tick and edge counters, configuration registers, a shift-add multiplier,
// a restoring divider and the result register.
// ---------------------------------------------------------------------------
`include "reciprocal_frequency_counter_unit_assert.svh"

module rfc_datapath import rfc_pkg::*; #(
  parameter int TICK_BITS = 48,
  parameter int EDGE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  signal_level,
  input  rfc_cmd_t              cmd,
  output rfc_status_t           status,
  rfc_out_if.source             results
);

  localparam int PROD_W = EDGE_BITS + CLK_HZ_W;
  localparam int CMP_W  = (TICK_BITS > MIN_WIN_W) ? TICK_BITS : MIN_WIN_W;
  localparam logic [TICK_BITS-1:0] TICK_MAX = '1;
  localparam logic [EDGE_BITS-1:0] EDGE_MAX = '1;

  logic [MIN_WIN_W-1:0] min_window;
  logic [CLK_HZ_W-1:0]  clock_hz;
  logic                 prev_level;
  logic [TICK_BITS-1:0] tick_count;
  logic [EDGE_BITS-1:0] edge_count;

  logic [EDGE_BITS-1:0] mplier;
  logic [PROD_W-1:0]    acc;
  logic [TICK_BITS-1:0] dvsr;
  logic [EDGE_BITS-1:0] win_edges;
  logic [TICK_BITS-1:0] rem;
  logic [FREQ_W-1:0]    quot;
  logic                 quot_ovf;
  logic                 out_valid;

  logic                 falling;
  logic                 close;
  logic [TICK_BITS-1:0] ticks_new;
  logic [EDGE_BITS-1:0] edges_new;
  logic [PROD_W-1:0]    mul_sum;
  logic [TICK_BITS:0]   rem_sh;
  logic [TICK_BITS:0]   rem_diff;
  logic                 div_ge;

  // Counter updates for the sample on the input, and the window-close test.
  always_comb begin
    falling   = prev_level && !signal_level;
    ticks_new = (tick_count == TICK_MAX) ? tick_count : tick_count + 1'b1;
    edges_new = (edge_count == EDGE_MAX) ? edge_count : edge_count + 1'b1;
    close     = falling && (CMP_W'(ticks_new) >= CMP_W'(min_window));
  end

  // One multiplier bit per step, most significant first.
  assign mul_sum = {acc[PROD_W-2:0], 1'b0}
                 + (mplier[EDGE_BITS-1] ? PROD_W'(clock_hz) : '0);

  // One quotient bit per step; the product shifts out of acc and zeros
  // follow it, which supplies the fraction bits of the dividend.
  always_comb begin
    rem_sh   = {rem, acc[PROD_W-1]};
    rem_diff = rem_sh - {1'b0, dvsr};
    div_ge   = (rem_sh >= {1'b0, dvsr});
  end

  always_comb begin
    status.close    = close;
    status.out_free = !out_valid || results.ready;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_window <= MIN_WIN_RESET;
      clock_hz   <= CLK_HZ_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MIN_WINDOW: min_window <= cfg_data;
        REG_CLOCK_HZ:   clock_hz   <= cfg_data[CLK_HZ_W-1:0];
        default: ;
      endcase
    end
  end

  // Level history and window counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level <= 1'b0;
      tick_count <= '0;
      edge_count <= '0;
    end else if (cmd.accept) begin
      prev_level <= signal_level;
      if (close) begin
        tick_count <= '0;
        edge_count <= '0;
      end else begin
        tick_count <= ticks_new;
        if (falling) begin
          edge_count <= edges_new;
        end
      end
    end
  end

  // Multiply and divide operands.
  always_ff @(posedge clk) begin
    if (cmd.accept && close) begin
      mplier    <= edges_new;
      win_edges <= edges_new;
      dvsr      <= ticks_new;
      acc       <= '0;
      rem       <= '0;
      quot      <= '0;
      quot_ovf  <= 1'b0;
    end else if (cmd.mul_step) begin
      acc    <= mul_sum;
      mplier <= {mplier[EDGE_BITS-2:0], 1'b0};
    end else if (cmd.div_step) begin
      acc      <= {acc[PROD_W-2:0], 1'b0};
      rem      <= div_ge ? rem_diff[TICK_BITS-1:0] : rem_sh[TICK_BITS-1:0];
      quot     <= {quot[FREQ_W-2:0], div_ge};
      quot_ovf <= quot_ovf || quot[FREQ_W-1];
    end
  end

  // Result register and its valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      results.frequency_q16   <= quot_ovf ? '1 : quot;
      results.edges_in_window <= OUT_EDGE_W'(win_edges);
      results.window_ticks    <= OUT_TICK_W'(dvsr);
    end
  end

  assign results.valid = out_valid;

  // A window close clears both counters.
  `RFC_ASSERT_NXT(a_close_clears, clk, rst, cmd.accept && close, tick_count == '0 && edge_count == '0)
  // Between closes the tick counter, below its maximum, advances by one per accepted sample.
  `RFC_ASSERT_NXT(a_tick_adv, clk, rst, cmd.accept && !close && tick_count != TICK_MAX, tick_count == $past(tick_count) + 1'b1)
  // A load always presents a result.
  `RFC_ASSERT_NXT(a_load_valid, clk, rst, cmd.out_load, out_valid)

endmodule

/* design/reciprocal_frequency_counter_unit.sv */
// ---------------------------------------------------------------------------
// reciprocal_frequency_counter_unit
// Counts ticks and falling edges of a sampled level; when a falling edge
// closes a window of at least the minimum length, reports
// edges * clock_hz / ticks in Q24.16 hertz with the edge and tick counts.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Contents
//  samples   in         signal_level
//  results   out        frequency_q16, edges_in_window, window_ticks
//  cfg       in         cfg_write, cfg_index, cfg_data (write only)
//
//  A sample that does not close a window leaves the unit ready for the next sample.
//  A closing sample holds off the next sample until the sequencer has run
//  EDGE_BITS shift-add multiply steps and EDGE_BITS + 44 restoring divide
//  steps on one shared accumulator and handed the result to the output.
//  The result waits in an output register; while it is stalled, the next
//  finished measurement waits in the sequencer and no sample is taken.
//  Reset clears the counters and restores the register defaults at once.
//
module reciprocal_frequency_counter_unit import rfc_pkg::*; #(
  parameter int TICK_BITS = 48,
  parameter int EDGE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rfc_in_if.sink                samples,
  rfc_out_if.source             results
);

  rfc_cmd_t    cmd;
  rfc_status_t status;
  logic        in_ready;

  assign samples.ready = in_ready;

  // Sequencer.
  rfc_ctrl #(
    .EDGE_BITS(EDGE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Counters and arithmetic.
  rfc_datapath #(
    .TICK_BITS(TICK_BITS),
    .EDGE_BITS(EDGE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .signal_level (samples.signal_level),
    .cmd          (cmd),
    .status       (status),
    .results      (results)
  );

endmodule
